### sv/blr_pkg.sv
// Shared constants for the line rasterizer: field widths and queue depth.
// No dependencies; imported by the top, the front and the walk modules.
package blr_pkg;

  localparam int unsigned CoordFieldW  = 6;  // width of coordinate ports
  localparam int unsigned ColorW       = 4;  // width of the color ports
  localparam int unsigned CoordWidthDefault = 6;  // grid is 2**CoordWidth per side
  localparam int unsigned QueueDepth   = 2;  // depth of line and point queues

endpackage

### sv/bresenham_line_rasterizer.sv
// Bresenham line rasterizer: a line request in, one point per result beat.
// A request passes through the line queue and the walk registers into the
// result queue before its first point can be taken.
// Each line gives max(|dx|,|dy|)+1 points, at most 2**COORD_WIDTH (64); the
// walk emits one point per cycle while the result queue has room, and the next
// line loads as the end point leaves. Reset (rst_ni low, async) empties both
// queues and idles the walk.
module bresenham_line_rasterizer #(
  parameter int unsigned COORD_WIDTH = blr_pkg::CoordWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [blr_pkg::CoordFieldW-1:0] start_x_i,
  input  logic [blr_pkg::CoordFieldW-1:0] start_y_i,
  input  logic [blr_pkg::CoordFieldW-1:0] end_x_i,
  input  logic [blr_pkg::CoordFieldW-1:0] end_y_i,
  input  logic [blr_pkg::ColorW-1:0]      color_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [blr_pkg::CoordFieldW-1:0] point_x_o,
  output logic [blr_pkg::CoordFieldW-1:0] point_y_o,
  output logic [blr_pkg::ColorW-1:0]      point_color_o,
  output logic                            last_o
);
  import blr_pkg::*;

  // Line descriptor: six coordinates/deltas, two step signs, error, color.
  localparam int unsigned DescW  = 6 * COORD_WIDTH + 2 + (COORD_WIDTH + 2) + ColorW;
  // Point beat: x, y, last mark, color.
  localparam int unsigned PointW = 2 * COORD_WIDTH + 1 + ColorW;

  logic [DescW-1:0]       desc;
  logic                   desc_empty, desc_pop;
  logic [PointW-1:0]      walk_point, out_point;
  logic                   walk_push, out_full;
  logic [COORD_WIDTH-1:0] pt_x, pt_y;
  logic                   pt_last;
  logic [ColorW-1:0]      pt_color;

  // Front: classify the request and queue it, so the walk can stall alone.
  blr_front #(
    .CoordWidth(COORD_WIDTH),
    .DescW     (DescW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .color_i     (color_i),
    .desc_pop_i  (desc_pop),
    .desc_o      (desc),
    .desc_empty_o(desc_empty)
  );

  // Back: step along the line, one point a cycle while the result queue has room.
  blr_walk #(
    .CoordWidth(COORD_WIDTH),
    .DescW     (DescW),
    .PointW    (PointW)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc),
    .desc_empty_i(desc_empty),
    .desc_pop_o  (desc_pop),
    .out_push_o  (walk_push),
    .out_data_o  (walk_point),
    .out_full_i  (out_full)
  );

  // Result queue: hold finished points so a stalled consumer does not stop
  // the walk until both entries are filled.
  blr_fifo #(
    .Width(PointW),
    .Depth(QueueDepth)
  ) u_point_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (walk_push),
    .data_i (walk_point),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_point),
    .empty_o(empty)
  );

  assign {pt_color, pt_last, pt_y, pt_x} = out_point;

  // Widen grid coordinates back to the port width.
  assign point_x_o     = CoordFieldW'(pt_x);
  assign point_y_o     = CoordFieldW'(pt_y);
  assign point_color_o = pt_color;
  assign last_o        = pt_last;

`ifndef SYNTHESIS
  a_last_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_push && walk_point[2*COORD_WIDTH]) |->
      (u_walk.x_q == u_walk.tx_q) && (u_walk.y_q == u_walk.ty_q))
    else $error("last mark on a point that is not the end point");
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_push |-> !out_full)
    else $error("walk pushed into a full result queue");
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop |-> !desc_empty)
    else $error("walk took a line from an empty queue");
`endif

endmodule

### sv/blr_fifo.sv
// Small register queue used between the front, the walk and the result port.
// Depends on nothing; Depth must be a power of two, at least 2.
module blr_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + AddrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + AddrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_ok && !pop_ok) begin
      count_d = count_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_ok) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not advance on a lone push");
  a_count_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !push_ok) |=> count_q == $past(count_q) - CntW'(1))
    else $error("queue count did not drop on a lone pop");
`endif

endmodule

### sv/blr_front.sv
// Front of the rasterizer: takes line requests, works out deltas, step
// directions and the initial error, and queues the line descriptor.
// Depends on blr_pkg and blr_fifo.
module blr_front #(
  parameter int unsigned CoordWidth = blr_pkg::CoordWidthDefault,
  parameter int unsigned DescW      = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [blr_pkg::CoordFieldW-1:0] start_x_i,
  input  logic [blr_pkg::CoordFieldW-1:0] start_y_i,
  input  logic [blr_pkg::CoordFieldW-1:0] end_x_i,
  input  logic [blr_pkg::CoordFieldW-1:0] end_y_i,
  input  logic [blr_pkg::ColorW-1:0]      color_i,
  input  logic                            desc_pop_i,
  output logic [DescW-1:0]                desc_o,
  output logic                            desc_empty_o
);
  import blr_pkg::*;

  localparam int unsigned ErrW = CoordWidth + 2;

  logic [CoordWidth-1:0] x, y, tx, ty, dx, dy;
  logic                  sxn, syn;
  logic signed [ErrW-1:0] err0;
  logic [DescW-1:0]      desc;

  // Drop coordinate bits beyond the grid.
  assign x  = start_x_i[CoordWidth-1:0];
  assign y  = start_y_i[CoordWidth-1:0];
  assign tx = end_x_i[CoordWidth-1:0];
  assign ty = end_y_i[CoordWidth-1:0];

  assign dx   = (tx >= x) ? tx - x : x - tx;
  assign dy   = (ty >= y) ? ty - y : y - ty;
  assign sxn  = !(x < tx);
  assign syn  = !(y < ty);
  assign err0 = $signed({2'b00, dx}) - $signed({2'b00, dy});

  assign desc = {color_i, err0, syn, sxn, dy, dx, ty, tx, y, x};

  blr_fifo #(
    .Width(DescW),
    .Depth(QueueDepth)
  ) u_desc_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (desc),
    .full_o (full_o),
    .pop_i  (desc_pop_i),
    .data_o (desc_o),
    .empty_o(desc_empty_o)
  );

endmodule

### sv/blr_walk.sv
// Back of the rasterizer: walks one queued line with the Bresenham error term,
// pushing a point per cycle toward the result queue while it has room.
// Depends on blr_pkg.
module blr_walk #(
  parameter int unsigned CoordWidth = blr_pkg::CoordWidthDefault,
  parameter int unsigned DescW      = 1,
  parameter int unsigned PointW     = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DescW-1:0]  desc_i,
  input  logic              desc_empty_i,
  output logic              desc_pop_o,
  output logic              out_push_o,
  output logic [PointW-1:0] out_data_o,
  input  logic              out_full_i
);
  import blr_pkg::*;

  localparam int unsigned ErrW = CoordWidth + 2;

  logic                   busy_q, busy_d;
  logic [CoordWidth-1:0]  x_q, x_d, y_q, y_d, tx_q, tx_d, ty_q, ty_d;
  logic [CoordWidth-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic                   sxn_q, sxn_d, syn_q, syn_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic [ColorW-1:0]      color_q, color_d;

  logic [CoordWidth-1:0]  in_x, in_y, in_tx, in_ty, in_dx, in_dy;
  logic                   in_sxn, in_syn;
  logic signed [ErrW-1:0] in_err;
  logic [ColorW-1:0]      in_color;

  logic                   at_end, step_x, step_y;
  logic signed [ErrW-1:0] dx_s, dy_s, err_step;
  logic signed [ErrW:0]   e2, dx_w, dy_w;

  assign {in_color, in_err, in_syn, in_sxn, in_dy, in_dx, in_ty, in_tx, in_y, in_x} = desc_i;

  assign at_end = (x_q == tx_q) && (y_q == ty_q);
  assign dx_s   = $signed({2'b00, dx_q});
  assign dy_s   = $signed({2'b00, dy_q});
  // The doubled error needs one bit more than the error itself.
  assign dx_w   = $signed({3'b000, dx_q});
  assign dy_w   = $signed({3'b000, dy_q});
  assign e2     = $signed({err_q, 1'b0});
  assign step_x = e2 > -dy_w;
  assign step_y = e2 < dx_w;
  assign err_step = err_q - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);

  assign out_push_o = busy_q && !out_full_i;
  assign out_data_o = {color_q, at_end, y_q, x_q};
  // Load a line when idle, or the next line in the cycle the end point leaves.
  assign desc_pop_o = !desc_empty_i && (!busy_q || (out_push_o && at_end));

  always_comb begin
    busy_d  = busy_q;
    x_d     = x_q;
    y_d     = y_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    sxn_d   = sxn_q;
    syn_d   = syn_q;
    err_d   = err_q;
    color_d = color_q;
    if (desc_pop_o) begin
      busy_d  = 1'b1;
      x_d     = in_x;
      y_d     = in_y;
      tx_d    = in_tx;
      ty_d    = in_ty;
      dx_d    = in_dx;
      dy_d    = in_dy;
      sxn_d   = in_sxn;
      syn_d   = in_syn;
      err_d   = in_err;
      color_d = in_color;
    end else if (out_push_o && at_end) begin
      busy_d = 1'b0;
    end else if (out_push_o) begin
      err_d = err_step;
      if (step_x) begin
        x_d = sxn_q ? x_q - CoordWidth'(1) : x_q + CoordWidth'(1);
      end
      if (step_y) begin
        y_d = syn_q ? y_q - CoordWidth'(1) : y_q + CoordWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    tx_q    <= tx_d;
    ty_q    <= ty_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    sxn_q   <= sxn_d;
    syn_q   <= syn_d;
    err_q   <= err_d;
    color_q <= color_d;
  end

`ifndef SYNTHESIS
  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_full_i) |=> $stable(x_q) && $stable(y_q) && $stable(err_q))
    else $error("walk advanced while the point queue was full");
  a_end_releases : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && at_end) |=> busy_q == $past(desc_pop_o))
    else $error("walk busy state wrong after end point");
  a_pop_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |-> (!busy_q || (out_push_o && at_end)))
    else $error("line taken while a walk was in progress");
`endif

endmodule
